/* rtl/bpm_pkg.sv */
// shared types, constants and helpers for the bit plane modulation builder
`default_nettype none

package bpm_pkg;

    // panel geometry
    localparam int PANEL_ROWS = 20;
    localparam int PANEL_COLS = 20;
    localparam int PLANES     = 4;
    localparam int ROW_IDX_W  = (PANEL_ROWS > 1) ? $clog2(PANEL_ROWS) : 1;
    localparam int ROW_W      = PLANES * PANEL_COLS;

    // field widths
    localparam int FUNC_W      = 2;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 5;
    localparam int INTENS_W    = 8;
    localparam int PLANE_W     = 2;
    localparam int WORD_W      = 20;
    localparam int DELAY_W     = 20;
    localparam int DUTY_W      = 8;
    localparam int BASE_W      = 16;
    localparam int WEIGHT_W    = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // register reset values
    localparam logic [DUTY_W-1:0] DUTY_RESET = 8'd255;
    localparam logic              GRAY_RESET = 1'b1;
    localparam logic [BASE_W-1:0] BASE_RESET = 16'd450;

    // modulation constants
    localparam logic [WEIGHT_W-1:0] WEIGHT_TWO_LEVEL = 4'd15;
    localparam logic [PLANES-1:0]   MASK_TWO_LEVEL   = 4'h1;
    localparam logic [PLANES-1:0]   MASK_SIXTEEN     = 4'hF;
    localparam int                  DUTY_FULL        = 255;
    localparam int                  ON_OVERHEAD      = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY = 2'd0,
        CFG_GRAY = 2'd1,
        CFG_BASE = 2'd2
    } cfg_idx_t;

    // one store operation, issued as the input stage advances
    typedef struct packed {
        logic                   en;
        func_t                  func;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
        logic [PLANES-1:0]      bits;
        logic [PLANE_W-1:0]     plane;
    } store_op_t;

    function automatic logic [WEIGHT_W-1:0] plane_weight(
        input logic               gray,
        input logic [PLANE_W-1:0] plane
    );
        logic [WEIGHT_W-1:0] w;
        if (!gray) begin
            w = (plane == '0) ? WEIGHT_TWO_LEVEL : '0;
        end else begin
            w = WEIGHT_W'(1) << plane;
        end
        return w;
    endfunction

    function automatic logic row_in_range(input logic [ROW_FIELD_W-1:0] row);
        return {1'b0, row} < (ROW_FIELD_W + 1)'(PANEL_ROWS);
    endfunction

endpackage

`default_nettype wire

/* rtl/bpm_plane_store.sv */
// plane store: per-row register words, or-in pixel writes, single clear, registered read
`default_nettype none

module bpm_plane_store (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire bpm_pkg::store_op_t       op,
    output logic [bpm_pkg::WORD_W-1:0]    rd_word
);
    import bpm_pkg::*;

    logic [ROW_W-1:0]  store_reg [PANEL_ROWS];
    logic [ROW_W-1:0]  set_mask;
    logic [ROW_W-1:0]  row_word;
    logic [WORD_W-1:0] plane_word;
    logic [WORD_W-1:0] rd_word_reg;
    logic              row_ok;
    logic              col_ok;
    logic [ROW_IDX_W-1:0] ridx;

    assign row_ok = row_in_range(op.row);
    assign col_ok = op.col < COL_FIELD_W'(PANEL_COLS);
    assign ridx   = op.row[ROW_IDX_W-1:0];

    always_comb begin
        for (int p = 0; p < PLANES; p++) begin
            for (int c = 0; c < PANEL_COLS; c++) begin
                set_mask[p*PANEL_COLS + c] = op.bits[p] && (op.col == COL_FIELD_W'(c));
            end
        end
    end

    assign row_word = row_ok ? store_reg[ridx] : '0;

    always_comb begin
        plane_word = '0;
        for (int p = 0; p < PLANES; p++) begin
            if (op.plane == PLANE_W'(p)) begin
                plane_word = row_word[p*PANEL_COLS +: WORD_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < PANEL_ROWS; r++) begin
                store_reg[r] <= '0;
            end
        end else if (op.en) begin
            case (op.func)
                FUNC_CLEAR: begin
                    for (int r = 0; r < PANEL_ROWS; r++) begin
                        store_reg[r] <= '0;
                    end
                end
                FUNC_WRITE: begin
                    if (row_ok && col_ok) begin
                        store_reg[ridx] <= store_reg[ridx] | set_mask;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (op.en) begin
            rd_word_reg <= plane_word;
        end
    end

    assign rd_word = rd_word_reg;

endmodule

`default_nettype wire

/* rtl/bpm_delay_calc.sv */
// plane on-time delay: base*duty, times weight, divide by 255, minus overhead
`default_nettype none

module bpm_delay_calc (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [bpm_pkg::DUTY_W-1:0]    duty,
    input  wire logic                          gray,
    input  wire logic [bpm_pkg::BASE_W-1:0]    base,
    input  wire logic [bpm_pkg::PLANE_W-1:0]   plane,
    output logic [bpm_pkg::DELAY_W-1:0]        delay
);
    import bpm_pkg::*;

    localparam int PROD_W   = BASE_W + DUTY_W;
    localparam int SCALED_W = PROD_W + WEIGHT_W;
    localparam int SUM_W    = SCALED_W + 1;
    localparam int QUO_W    = SUM_W - 8;
    localparam int REM_W    = 9;

    logic [PROD_W-1:0]   p_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [SCALED_W-1:0] x_reg;
    logic [SCALED_W-1:0] x3_reg;
    logic [QUO_W-1:0]    q_reg;
    logic [SUM_W-1:0]    t_sum;
    logic [SUM_W-1:0]    q_times;
    logic [SUM_W-1:0]    rem_full;
    logic [REM_W-1:0]    rem;
    logic [QUO_W-1:0]    q_fix;

    // x/255 estimate from x/256 + x/256^2 + ..., never high, at most one low
    assign t_sum = SUM_W'(x_reg) + SUM_W'(x_reg >> 8) + SUM_W'(x_reg >> 16)
                 + SUM_W'(x_reg >> 24);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg  <= PROD_W'(base) * PROD_W'(duty);
            w_reg  <= plane_weight(gray, plane);
            x_reg  <= SCALED_W'(p_reg) * SCALED_W'(w_reg);
            q_reg  <= QUO_W'(t_sum >> 8);
            x3_reg <= x_reg;
        end
    end

    // remainder stays below twice the divisor, one correction step
    assign q_times  = (SUM_W'(q_reg) << 8) - SUM_W'(q_reg);
    assign rem_full = SUM_W'(x3_reg) - q_times;
    assign rem      = rem_full[REM_W-1:0];
    assign q_fix    = (rem >= REM_W'(DUTY_FULL)) ? q_reg + QUO_W'(1) : q_reg;

    assign delay = (q_fix > QUO_W'(ON_OVERHEAD)) ? DELAY_W'(q_fix - QUO_W'(ON_OVERHEAD))
                                                 : '0;

endmodule

`default_nettype wire

/* rtl/bit_plane_modulation_builder_unit.sv */
// bit plane modulation builder: plane store with read-out of plane words and on-times
//
// usage:
//   s_ channel takes one item per beat: s_tuser carries the function (clear store,
//   write pixel, read plane word), s_tdata the row, column, intensity and plane.
//   clear and pixel-write items give no result; a read gives one m_ beat with the
//   row's column word for the plane and that plane's on-time delay in cycles.
//   cfg_wr_en/cfg_index/cfg_wdata write duty level, gray mode and base cycles;
//   write them only while no item is in flight.
// timing:
//   one item per cycle unless m_ stalls; a read result passes the input register,
//   store read plus base*duty product, weight product, divide estimate and output
//   register with divide correction before it appears on m_.
//   a store write is visible to the item right behind it.
// stall:
//   when m_tvalid is held without m_tready the whole pipe freezes and s_tready
//   drops in the same cycle; nothing is lost or repeated.
// reset:
//   aresetn low clears the store, empties the pipe and loads duty 255,
//   sixteen-level mode and 450 base cycles.
`default_nettype none

module bit_plane_modulation_builder_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // slave side
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // row_index[4:0], col_index[9:5], intensity[17:10], plane_index[19:18], zero pad
    input  wire logic [bpm_pkg::S_TDATA_W-1:0]     s_tdata,
    // func[1:0]
    input  wire logic [bpm_pkg::FUNC_W-1:0]        s_tuser,
    // master side
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // column_word[19:0], plane_delay[39:20]
    output logic [bpm_pkg::M_TDATA_W-1:0]          m_tdata,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [bpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bpm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import bpm_pkg::*;

    logic [DUTY_W-1:0] duty_reg;
    logic              gray_reg;
    logic [BASE_W-1:0] base_reg;

    logic              en;
    logic              in_vld_reg;
    func_t             in_func_reg;
    logic [ROW_FIELD_W-1:0] in_row_reg;
    logic [COL_FIELD_W-1:0] in_col_reg;
    logic [INTENS_W-1:0]    in_int_reg;
    logic [PLANE_W-1:0]     in_plane_reg;

    logic              rd1_vld_reg;
    logic              rd2_vld_reg;
    logic              rd3_vld_reg;
    logic              out_vld_reg;
    logic              kill1_reg;
    logic [WORD_W-1:0] word2_reg;
    logic [WORD_W-1:0] word3_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic [DELAY_W-1:0] out_delay_reg;

    logic [PLANES-1:0] bit_mask;
    logic              kill_next;
    store_op_t         op;
    logic [WORD_W-1:0] rd_word;
    logic [DELAY_W-1:0] delay;

    // whole pipe advances unless a result is stuck at the output
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg <= DUTY_RESET;
            gray_reg <= GRAY_RESET;
            base_reg <= BASE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DUTY: duty_reg <= cfg_wdata[DUTY_W-1:0];
                CFG_GRAY: gray_reg <= cfg_wdata[0];
                CFG_BASE: base_reg <= cfg_wdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            rd1_vld_reg <= 1'b0;
            rd2_vld_reg <= 1'b0;
            rd3_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg  <= s_tvalid;
            rd1_vld_reg <= in_vld_reg && (in_func_reg == FUNC_READ);
            rd2_vld_reg <= rd1_vld_reg;
            rd3_vld_reg <= rd2_vld_reg;
            out_vld_reg <= rd3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_func_reg   <= func_t'(s_tuser);
            in_row_reg    <= s_tdata[4:0];
            in_col_reg    <= s_tdata[9:5];
            in_int_reg    <= s_tdata[17:10];
            in_plane_reg  <= s_tdata[19:18];
            kill1_reg     <= kill_next;
            word2_reg     <= kill1_reg ? '0 : rd_word;
            word3_reg     <= word2_reg;
            out_word_reg  <= word3_reg;
            out_delay_reg <= delay;
        end
    end

    assign bit_mask  = in_int_reg[PLANES-1:0] & (gray_reg ? MASK_SIXTEEN : MASK_TWO_LEVEL);
    // dark duty, unused plane or missing row read as an empty word
    assign kill_next = (duty_reg == '0) || (plane_weight(gray_reg, in_plane_reg) == '0)
                     || !row_in_range(in_row_reg);

    always_comb begin
        op.en    = en && in_vld_reg;
        op.func  = in_func_reg;
        op.row   = in_row_reg;
        op.col   = in_col_reg;
        op.bits  = bit_mask;
        op.plane = in_plane_reg;
    end

    bpm_plane_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .rd_word (rd_word)
    );

    bpm_delay_calc u_delay (
        .aclk  (aclk),
        .en    (en),
        .duty  (duty_reg),
        .gray  (gray_reg),
        .base  (base_reg),
        .plane (in_plane_reg),
        .delay (delay)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_delay_reg, out_word_reg};

    a_dark_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (duty_reg == '0) |-> (m_tdata == '0))
        else $error("result not dark at duty zero");

    a_read_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        en && rd3_vld_reg |=> m_tvalid)
        else $error("read result lost before output");

    a_freeze_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable({in_vld_reg, rd1_vld_reg, rd2_vld_reg, rd3_vld_reg}))
        else $error("pipe moved during output stall");

    a_two_level_planes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !gray_reg && (base_reg == '0) |-> (m_tdata[DELAY_W+WORD_W-1:WORD_W] == '0))
        else $error("delay nonzero with zero base");

endmodule

`default_nettype wire
